@@ hw/rtl/sca_pkg.sv @@
// Shared constants, types and the sigmoid table for the sigmoid contrast pixel block.
package sca_pkg;

    // Sigmoid table geometry
    localparam int SIG_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(SIG_ENTRIES);
    localparam int TBL_LAST    = SIG_ENTRIES - 1;

    // Pixel and register widths
    localparam int PIX_W  = 8;
    localparam int GAIN_W = 8;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(20);

    // p in Q12: p = round(|d| * gain * 4096 / 2250)
    localparam int X_W   = 15;   // |d| * gain
    localparam int N_W   = 27;   // |d| * gain * 4096 + 1125
    localparam int MAG_W = 16;   // |pq|
    localparam int PQ_DIV = 2250;
    localparam logic [N_W-1:0] PQ_HALF = N_W'(1125);
    localparam logic [20:0] PQ_RECIP = 21'((64'd1 << 32) / 64'(PQ_DIV));

    // Table position: pos = floor(u * (N-1) / 18), Q12
    localparam int U_W   = 17;
    localparam logic [U_W-1:0] OFFSET_Q12 = U_W'(9 * 4096);
    localparam logic [U_W-1:0] RANGE_Q12  = U_W'(18 * 4096);
    localparam int W_W   = U_W + IDX_W;
    localparam int POS_W = IDX_W + 12;
    localparam int POS_DIV = 18;
    localparam logic [27:0] POS_RECIP = 28'((64'd1 << 32) / 64'(POS_DIV));

    // Interpolation and output factor
    localparam int FR_W     = 12;
    localparam int SIG_W    = 16;
    localparam int FACTOR_W = 17;
    localparam logic [FACTOR_W-1:0] BIAS_Q16 = FACTOR_W'(19661);

    // Pipeline depth, input register through output register
    localparam int STAGE_CNT = 11;

    typedef logic [SIG_W-1:0] t_sig_rom [SIG_ENTRIES];

    // Restoring division, only used while the table is built
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // One table entry: sigmoid at x_i = 9 * (2i - (N-1)) / (N-1), Q0.16
    function automatic logic [SIG_W-1:0] sig_entry(input int unsigned i);
        longint unsigned last;
        longint unsigned one;
        longint unsigned twice;
        longint unsigned m;
        longint unsigned f;
        longint unsigned term;
        longint unsigned e;
        longint unsigned num;
        longint unsigned den;
        longint unsigned v;
        longint          sum;
        bit              nonneg;
        last   = 64'(TBL_LAST);
        one    = 64'd1 << 32;
        twice  = 64'(i) * 64'd2;
        nonneg = (twice >= last);
        m      = nonneg ? (twice - last) : (last - twice);
        f      = udiv64(64'd9 * m * (64'd1 << 28), last);
        // e^-f by a Taylor series, Q32
        sum  = signed'(one);
        term = one;
        for (int n = 1; n <= 20; n++) begin
            term = udiv64((term * f) >> 32, 64'(n));
            if ((n & 1) == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > signed'(one)) begin
            sum = signed'(one);
        end
        e = unsigned'(sum);
        // raise to the 16th power
        for (int k = 0; k < 4; k++) begin
            if (e < one) begin
                e = (e * e) >> 32;
            end
        end
        num = nonneg ? one : e;
        den = one + e;
        v   = udiv64(num * 64'd65536 + (den >> 1), den);
        if (v > 64'd65535) begin
            v = 64'd65535;
        end
        return v[SIG_W-1:0];
    endfunction

    function automatic t_sig_rom build_sig_rom();
        t_sig_rom rom;
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            rom[i] = sig_entry(i);
        end
        return rom;
    endfunction

    localparam t_sig_rom SIG_ROM = build_sig_rom();

endpackage

@@ hw/rtl/sigmoid_contrast_pixel_top.sv @@
// Top level of the sigmoid contrast pixel block: handshake, gain register, three channels.
//
//  Channel   Direction  Signals                                  Moves
//  ------    ---------  ---------------------------------------  -------------------------
//  input     in         i_valid / o_stall, i_chan0..2_in         one pixel item
//  output    out        o_valid / i_stall, o_chan0..2_out        one adjusted pixel item
//  config    in         i_cfg_we, i_cfg_wdata                    contrast gain, tenths
//
//  One item per clock sustained while i_stall stays low; an accepted item enters the first
//  stage, and o_valid is the valid bit of the last stage.
//  Eleven register stages, the table ROM read being one of them; each stage has a valid
//  bit and advances when it is empty or its successor advances, so bubbles are squeezed.
//  Reset (synchronous, active low) empties the pipe and sets the gain to 20.
//  A held i_stall freezes a full last stage and every full stage packed behind it; nothing is dropped or repeated.
module sigmoid_contrast_pixel_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sca_pkg::GAIN_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [sca_pkg::PIX_W-1:0]     i_chan0_in,
    input  logic [sca_pkg::PIX_W-1:0]     i_chan1_in,
    input  logic [sca_pkg::PIX_W-1:0]     i_chan2_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sca_pkg::PIX_W-1:0]     o_chan0_out,
    output logic [sca_pkg::PIX_W-1:0]     o_chan1_out,
    output logic [sca_pkg::PIX_W-1:0]     o_chan2_out
);

    logic [sca_pkg::GAIN_W-1:0]    r_gain;
    logic [sca_pkg::STAGE_CNT-1:0] r_vld;
    logic [sca_pkg::STAGE_CNT-1:0] stage_en;

    // gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= sca_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    // a stage may load when it is empty or its contents move on
    always_comb begin
        stage_en[sca_pkg::STAGE_CNT-1] = !r_vld[sca_pkg::STAGE_CNT-1] || !i_stall;
        for (int k = sca_pkg::STAGE_CNT - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < sca_pkg::STAGE_CNT; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !stage_en[0];
    assign o_valid = r_vld[sca_pkg::STAGE_CNT-1];

    // one datapath per color channel
    sca_chan u_chan0 (
        .i_clk  (i_clk),
        .i_en   (stage_en),
        .i_gain (r_gain),
        .i_pix  (i_chan0_in),
        .o_pix  (o_chan0_out)
    );

    sca_chan u_chan1 (
        .i_clk  (i_clk),
        .i_en   (stage_en),
        .i_gain (r_gain),
        .i_pix  (i_chan1_in),
        .o_pix  (o_chan1_out)
    );

    sca_chan u_chan2 (
        .i_clk  (i_clk),
        .i_en   (stage_en),
        .i_gain (r_gain),
        .i_pix  (i_chan2_in),
        .o_pix  (o_chan2_out)
    );

endmodule

@@ hw/rtl/sca_rom.sv @@
// Sigmoid table ROM with two registered read ports.
module sca_rom (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [sca_pkg::IDX_W-1:0]  i_addr0,
    input  logic [sca_pkg::IDX_W-1:0]  i_addr1,
    output logic [sca_pkg::SIG_W-1:0]  o_data0,
    output logic [sca_pkg::SIG_W-1:0]  o_data1
);

    logic [sca_pkg::SIG_W-1:0] r_data0;
    logic [sca_pkg::SIG_W-1:0] r_data1;

    // registered reads, held while the stage stalls
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data0 <= sca_pkg::SIG_ROM[i_addr0];
            r_data1 <= sca_pkg::SIG_ROM[i_addr1];
        end
    end

    assign o_data0 = r_data0;
    assign o_data1 = r_data1;

endmodule

@@ hw/rtl/sca_chan.sv @@
// Datapath of one color channel: contrast term, table lookup, interpolation, scaling.
module sca_chan (
    input  logic                            i_clk,
    input  logic [sca_pkg::STAGE_CNT-1:0]   i_en,
    input  logic [sca_pkg::GAIN_W-1:0]      i_gain,
    input  logic [sca_pkg::PIX_W-1:0]       i_pix,
    output logic [sca_pkg::PIX_W-1:0]       o_pix
);

    localparam int PROD_A_W = sca_pkg::N_W + 21;
    localparam int PROD_B_W = sca_pkg::W_W + 28;

    // channel value carried alongside the work
    logic [sca_pkg::PIX_W-1:0]    r_pix [sca_pkg::STAGE_CNT-1];

    logic                         r_neg1;
    logic                         r_neg2;
    logic                         r_neg3;
    logic [sca_pkg::X_W-1:0]      r_x;
    logic [sca_pkg::N_W-1:0]      r_n;
    logic [sca_pkg::MAG_W-1:0]    r_q0a;
    logic [sca_pkg::MAG_W-1:0]    r_mag;
    logic [sca_pkg::W_W-1:0]      r_w;
    logic [sca_pkg::W_W-1:0]      r_w5;
    logic [sca_pkg::POS_W-1:0]    r_q0b;
    logic [sca_pkg::IDX_W-1:0]    r_idx;
    logic [sca_pkg::IDX_W-1:0]    r_idx1;
    logic [sca_pkg::FR_W-1:0]     r_fr6;
    logic [sca_pkg::FR_W-1:0]     r_fr7;
    logic [28:0]                  r_a;
    logic [27:0]                  r_b;
    logic [sca_pkg::FACTOR_W-1:0] r_factor;
    logic [sca_pkg::PIX_W-1:0]    r_out;

    logic [sca_pkg::SIG_W-1:0]    t0;
    logic [sca_pkg::SIG_W-1:0]    t1;

    logic [sca_pkg::PIX_W-1:0]    d_mag;
    logic [sca_pkg::N_W-1:0]      n_val;
    logic [PROD_A_W-1:0]          prod_a;
    logic [sca_pkg::N_W-1:0]      rem_a;
    logic [sca_pkg::U_W-1:0]      u_val;
    logic [PROD_B_W-1:0]          prod_b;
    logic [sca_pkg::W_W-1:0]      rem_b;
    logic [sca_pkg::POS_W-1:0]    pos;
    logic [sca_pkg::IDX_W-1:0]    idx;
    logic [28:0]                  interp;
    logic [25:0]                  scaled;

    // stage 2: |v - 127|
    always_comb begin
        if (r_pix[0] < sca_pkg::PIX_W'(127)) begin
            d_mag = sca_pkg::PIX_W'(127) - r_pix[0];
        end else begin
            d_mag = r_pix[0] - sca_pkg::PIX_W'(127);
        end
    end

    // stage 3: n = x * 4096 + 1125, first quotient estimate of n / 2250
    assign n_val  = {r_x, 12'd0} + sca_pkg::PQ_HALF;
    assign prod_a = PROD_A_W'(n_val) * PROD_A_W'(sca_pkg::PQ_RECIP);

    // stage 4: correct the estimate by one
    assign rem_a = r_n - sca_pkg::N_W'(r_q0a * sca_pkg::N_W'(sca_pkg::PQ_DIV));

    // stage 5: offset and clamp p into the table range
    always_comb begin
        if (r_neg3) begin
            if (sca_pkg::U_W'(r_mag) > sca_pkg::OFFSET_Q12) begin
                u_val = '0;
            end else begin
                u_val = sca_pkg::OFFSET_Q12 - sca_pkg::U_W'(r_mag);
            end
        end else begin
            if (sca_pkg::U_W'(r_mag) > sca_pkg::RANGE_Q12 - sca_pkg::OFFSET_Q12) begin
                u_val = sca_pkg::RANGE_Q12;
            end else begin
                u_val = sca_pkg::OFFSET_Q12 + sca_pkg::U_W'(r_mag);
            end
        end
    end

    // stage 6: first quotient estimate of w / 18
    assign prod_b = PROD_B_W'(r_w) * PROD_B_W'(sca_pkg::POS_RECIP);

    // stage 7: correct, split into index and fraction
    assign rem_b = r_w5 - sca_pkg::W_W'(sca_pkg::W_W'(r_q0b) *
                                          sca_pkg::W_W'(sca_pkg::POS_DIV));
    assign pos   = r_q0b + sca_pkg::POS_W'(rem_b >= sca_pkg::W_W'(sca_pkg::POS_DIV));
    assign idx   = pos[sca_pkg::FR_W +: sca_pkg::IDX_W];

    // stage 8: table read
    sca_rom u_rom (
        .i_clk   (i_clk),
        .i_en    (i_en[7]),
        .i_addr0 (r_idx),
        .i_addr1 (r_idx1),
        .o_data0 (t0),
        .o_data1 (t1)
    );

    // stage 10: interpolated sigmoid in Q0.28, rounded to Q0.16
    assign interp = r_a + 29'(r_b) + 29'd2048;

    // stage 11: scale, round, saturate
    assign scaled = 26'(26'(r_pix[9]) * 26'(r_factor)) + 26'd32768;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pix[0] <= i_pix;
        end
        for (int k = 1; k < sca_pkg::STAGE_CNT - 1; k++) begin
            if (i_en[k]) begin
                r_pix[k] <= r_pix[k-1];
            end
        end
        if (i_en[1]) begin
            r_neg1 <= (r_pix[0] < sca_pkg::PIX_W'(127));
            r_x    <= sca_pkg::X_W'(d_mag) * sca_pkg::X_W'(i_gain);
        end
        if (i_en[2]) begin
            r_neg2 <= r_neg1;
            r_n    <= n_val;
            r_q0a  <= prod_a[32 +: sca_pkg::MAG_W];
        end
        if (i_en[3]) begin
            r_neg3 <= r_neg2;
            r_mag  <= r_q0a + sca_pkg::MAG_W'(rem_a >= sca_pkg::N_W'(sca_pkg::PQ_DIV));
        end
        if (i_en[4]) begin
            r_w <= sca_pkg::W_W'(u_val) * sca_pkg::W_W'(sca_pkg::TBL_LAST);
        end
        if (i_en[5]) begin
            r_w5  <= r_w;
            r_q0b <= prod_b[32 +: sca_pkg::POS_W];
        end
        if (i_en[6]) begin
            r_idx  <= idx;
            r_idx1 <= (idx == sca_pkg::IDX_W'(sca_pkg::TBL_LAST)) ? idx : idx + 1'b1;
            r_fr6  <= pos[sca_pkg::FR_W-1:0];
        end
        if (i_en[7]) begin
            r_fr7 <= r_fr6;
        end
        if (i_en[8]) begin
            r_a <= 29'(t0) * (29'd4096 - 29'(r_fr7));
            r_b <= 28'(t1) * 28'(r_fr7);
        end
        if (i_en[9]) begin
            r_factor <= sca_pkg::FACTOR_W'(interp[27:12]) + sca_pkg::BIAS_Q16;
        end
        if (i_en[10]) begin
            if (scaled[25:16] > 10'd255) begin
                r_out <= 8'd255;
            end else begin
                r_out <= scaled[23:16];
            end
        end
    end

    assign o_pix = r_out;

endmodule
